// File: hdl/assert_macros.svh
// ----------------------------------------------------------------------------
// assert_macros.svh
// Shared assertion macros for the heap engine RTL.
// ----------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Check that a condition implies another in the same cycle.
`define ASSERT_SAME(label, clk, rst_n, pre, post) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (pre) |-> (post)) \
        else $error("assertion failed: same-cycle implication");

// Check that a condition implies another in the next cycle.
`define ASSERT_NEXT(label, clk, rst_n, pre, post) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (pre) |=> (post)) \
        else $error("assertion failed: next-cycle implication");

`endif

// File: hdl/mmh_pkg.sv
`default_nettype none
// ----------------------------------------------------------------------------
// mmh_pkg
// Types, codes and defaults shared by the heap engine modules.
// ----------------------------------------------------------------------------
package mmh_pkg;

    localparam int CAPACITY_DEF = 512;

    // Request codes
    localparam logic [2:0] OP_INSERT = 3'd0;
    localparam logic [2:0] OP_DELMIN = 3'd1;
    localparam logic [2:0] OP_DELMAX = 3'd2;
    localparam logic [2:0] OP_REMOVE = 3'd3;
    localparam logic [2:0] OP_SEARCH = 3'd4;

    // Result status codes
    localparam logic [1:0] ST_OK       = 2'd0;
    localparam logic [1:0] ST_EMPTY    = 2'd1;
    localparam logic [1:0] ST_FULL     = 2'd2;
    localparam logic [1:0] ST_NOTFOUND = 2'd3;

    // Position pointer updates
    localparam logic [2:0] P_HOLD  = 3'd0;
    localparam logic [2:0] P_ZERO  = 3'd1;
    localparam logic [2:0] P_COUNT = 3'd2;
    localparam logic [2:0] P_LAST  = 3'd3;
    localparam logic [2:0] P_INC   = 3'd4;
    localparam logic [2:0] P_DEC   = 3'd5;

    // Read address selects
    localparam logic [2:0] RD_P    = 3'd0;
    localparam logic [2:0] RD_PM1  = 3'd1;
    localparam logic [2:0] RD_PP1  = 3'd2;
    localparam logic [2:0] RD_ZERO = 3'd3;
    localparam logic [2:0] RD_LAST = 3'd4;

    typedef struct packed {
        logic       load;
        logic [2:0] p_op;
        logic [2:0] rd_sel;
        logic       wr_en;
        logic       wr_from_rd;
        logic       cnt_inc;
        logic       cnt_dec;
        logic       set_status;
        logic [1:0] status_code;
        logic       set_found;
        logic       set_taken;
        logic       min_ld;
        logic       max_ld;
        logic       minmax_clr;
        logic       out_ld;
    } cmd_t;

    typedef struct packed {
        logic [2:0] op;
        logic       count_zero;
        logic       full;
        logic       p_zero;
        logic       p_end;
        logic       p1_end;
        logic       rd_gt;
        logic       rd_eq;
        logic       out_busy;
    } sts_t;

endpackage
`default_nettype wire

// File: hdl/mmh_datapath.sv
`default_nettype none
// ----------------------------------------------------------------------------
// mmh_datapath
// Key store kept in ascending order, pointer, count and result registers.
// ----------------------------------------------------------------------------
module mmh_datapath #(
    parameter int CAPACITY = mmh_pkg::CAPACITY_DEF
) (
    input  wire logic               clk,
    input  wire logic               rst_n,
    input  wire logic [2:0]         operation,
    input  wire logic signed [31:0] value,
    input  wire mmh_pkg::cmd_t      cmd,
    output mmh_pkg::sts_t           sts,
    input  wire logic               out_stall,
    output logic                    out_valid,
    output logic [1:0]              status,
    output logic                    found,
    output logic signed [31:0]      taken_value,
    output logic signed [31:0]      min_value,
    output logic signed [31:0]      max_value,
    output logic [9:0]              entry_count
);

    localparam int AW = (CAPACITY > 1) ? $clog2(CAPACITY) : 1;
    localparam int CW = $clog2(CAPACITY + 1);

    logic signed [31:0] mem [CAPACITY];

    logic [2:0]         op_reg;
    logic signed [31:0] val_reg;
    logic [CW-1:0]      p_reg, p_next;
    logic [CW-1:0]      cnt_reg;
    logic signed [31:0] rd_data_reg;
    logic [1:0]         res_status_reg;
    logic               res_found_reg;
    logic signed [31:0] res_taken_reg;
    logic signed [31:0] min_reg;
    logic signed [31:0] max_reg;

    logic               out_valid_reg;
    logic [1:0]         out_status_reg;
    logic               out_found_reg;
    logic signed [31:0] out_taken_reg;
    logic signed [31:0] out_min_reg;
    logic signed [31:0] out_max_reg;
    logic [9:0]         out_count_reg;

    logic [CW-1:0]      rd_idx;
    logic signed [31:0] wr_data;
    logic [CW:0]        p_plus1;
    logic [CW+9:0]      cnt_ext;

    assign p_plus1 = {1'b0, p_reg} + {{CW{1'b0}}, 1'b1};
    assign cnt_ext = {10'd0, cnt_reg};
    assign wr_data = cmd.wr_from_rd ? rd_data_reg : val_reg;

    // Select the pointer update
    always_comb
    begin
        unique case (cmd.p_op)
            mmh_pkg::P_HOLD:  p_next = p_reg;
            mmh_pkg::P_ZERO:  p_next = '0;
            mmh_pkg::P_COUNT: p_next = cnt_reg;
            mmh_pkg::P_LAST:  p_next = cnt_reg - CW'(1);
            mmh_pkg::P_INC:   p_next = p_reg + CW'(1);
            mmh_pkg::P_DEC:   p_next = p_reg - CW'(1);
            default:          p_next = p_reg;
        endcase
    end

    // Select the read address
    always_comb
    begin
        unique case (cmd.rd_sel)
            mmh_pkg::RD_P:    rd_idx = p_reg;
            mmh_pkg::RD_PM1:  rd_idx = p_reg - CW'(1);
            mmh_pkg::RD_PP1:  rd_idx = p_plus1[CW-1:0];
            mmh_pkg::RD_ZERO: rd_idx = '0;
            mmh_pkg::RD_LAST: rd_idx = cnt_reg - CW'(1);
            default:          rd_idx = p_reg;
        endcase
    end

    // Key store: one write and one registered read per cycle
    always_ff @(posedge clk)
    begin
        if (cmd.wr_en)
        begin
            mem[p_reg[AW-1:0]] <= wr_data;
        end
        rd_data_reg <= mem[rd_idx[AW-1:0]];
    end

    // Hold the request and working results
    always_ff @(posedge clk)
    begin
        if (cmd.load)
        begin
            op_reg  <= operation;
            val_reg <= value;
        end
        if (cmd.load)
        begin
            res_status_reg <= mmh_pkg::ST_OK;
        end
        else if (cmd.set_status)
        begin
            res_status_reg <= cmd.status_code;
        end
        if (cmd.load)
        begin
            res_found_reg <= 1'b0;
        end
        else if (cmd.set_found)
        begin
            res_found_reg <= 1'b1;
        end
        if (cmd.load)
        begin
            res_taken_reg <= '0;
        end
        else if (cmd.set_taken)
        begin
            res_taken_reg <= rd_data_reg;
        end
        if (cmd.minmax_clr)
        begin
            min_reg <= '0;
            max_reg <= '0;
        end
        else
        begin
            if (cmd.min_ld)
            begin
                min_reg <= rd_data_reg;
            end
            if (cmd.max_ld)
            begin
                max_reg <= rd_data_reg;
            end
        end
        if (cmd.out_ld)
        begin
            out_status_reg <= res_status_reg;
            out_found_reg  <= res_found_reg;
            out_taken_reg  <= res_taken_reg;
            out_min_reg    <= min_reg;
            out_max_reg    <= max_reg;
            out_count_reg  <= cnt_ext[9:0];
        end
    end

    // Advance pointer, count and output valid
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            p_reg         <= '0;
            cnt_reg       <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            p_reg <= p_next;
            if (cmd.cnt_inc)
            begin
                cnt_reg <= cnt_reg + CW'(1);
            end
            else if (cmd.cnt_dec)
            begin
                cnt_reg <= cnt_reg - CW'(1);
            end
            if (cmd.out_ld)
            begin
                out_valid_reg <= 1'b1;
            end
            else if (!out_stall)
            begin
                out_valid_reg <= 1'b0;
            end
        end
    end

    // Report status to the controller
    always_comb
    begin
        sts.op         = op_reg;
        sts.count_zero = (cnt_reg == '0);
        sts.full       = (cnt_reg == CW'(CAPACITY));
        sts.p_zero     = (p_reg == '0);
        sts.p_end      = (p_reg == cnt_reg);
        sts.p1_end     = (p_plus1 >= {1'b0, cnt_reg});
        sts.rd_gt      = (rd_data_reg > val_reg);
        sts.rd_eq      = (rd_data_reg == val_reg);
        sts.out_busy   = out_valid_reg && out_stall;
    end

    assign out_valid   = out_valid_reg;
    assign status      = out_status_reg;
    assign found       = out_found_reg;
    assign taken_value = out_taken_reg;
    assign min_value   = out_min_reg;
    assign max_value   = out_max_reg;
    assign entry_count = out_count_reg;

endmodule
`default_nettype wire

// File: hdl/mmh_ctrl.sv
`default_nettype none
// ----------------------------------------------------------------------------
// mmh_ctrl
// Sequencer that steps the datapath through insert, delete, remove and search.
// ----------------------------------------------------------------------------
module mmh_ctrl (
    input  wire logic          clk,
    input  wire logic          rst_n,
    input  wire logic          in_valid,
    output logic               in_stall,
    input  wire mmh_pkg::sts_t sts,
    output mmh_pkg::cmd_t      cmd
);

    localparam logic [3:0] S_IDLE    = 4'd0;
    localparam logic [3:0] S_DISP    = 4'd1;
    localparam logic [3:0] S_INS_RD  = 4'd2;
    localparam logic [3:0] S_INS_CMP = 4'd3;
    localparam logic [3:0] S_TK_RD   = 4'd4;
    localparam logic [3:0] S_TK_CAP  = 4'd5;
    localparam logic [3:0] S_SH_RD   = 4'd6;
    localparam logic [3:0] S_SH_WR   = 4'd7;
    localparam logic [3:0] S_SC_RD   = 4'd8;
    localparam logic [3:0] S_SC_CMP  = 4'd9;
    localparam logic [3:0] S_FIN     = 4'd10;
    localparam logic [3:0] S_FIN_MIN = 4'd11;
    localparam logic [3:0] S_FIN_MAX = 4'd12;
    localparam logic [3:0] S_DONE    = 4'd13;

    logic [3:0] state_reg, state_next;

    assign in_stall = (state_reg != S_IDLE);

    // Decode state into datapath commands
    always_comb
    begin
        state_next = state_reg;
        cmd        = '0;
        cmd.p_op   = mmh_pkg::P_HOLD;
        cmd.rd_sel = mmh_pkg::RD_P;
        unique case (state_reg)
            S_IDLE:
            begin
                if (in_valid)
                begin
                    cmd.load   = 1'b1;
                    state_next = S_DISP;
                end
            end
            S_DISP:
            begin
                unique case (sts.op)
                    mmh_pkg::OP_INSERT:
                    begin
                        if (sts.full)
                        begin
                            cmd.set_status  = 1'b1;
                            cmd.status_code = mmh_pkg::ST_FULL;
                            state_next      = S_FIN;
                        end
                        else
                        begin
                            cmd.p_op   = mmh_pkg::P_COUNT;
                            state_next = S_INS_RD;
                        end
                    end
                    mmh_pkg::OP_DELMIN, mmh_pkg::OP_DELMAX:
                    begin
                        if (sts.count_zero)
                        begin
                            cmd.set_status  = 1'b1;
                            cmd.status_code = mmh_pkg::ST_EMPTY;
                            state_next      = S_FIN;
                        end
                        else
                        begin
                            cmd.p_op   = (sts.op == mmh_pkg::OP_DELMIN) ?
                                         mmh_pkg::P_ZERO : mmh_pkg::P_LAST;
                            state_next = S_TK_RD;
                        end
                    end
                    mmh_pkg::OP_REMOVE, mmh_pkg::OP_SEARCH:
                    begin
                        if (sts.count_zero)
                        begin
                            cmd.set_status  = 1'b1;
                            cmd.status_code = mmh_pkg::ST_EMPTY;
                            state_next      = S_FIN;
                        end
                        else
                        begin
                            cmd.p_op   = mmh_pkg::P_ZERO;
                            state_next = S_SC_RD;
                        end
                    end
                    default:
                    begin
                        state_next = S_FIN;
                    end
                endcase
            end
            // Shift larger keys up one slot until the new key fits
            S_INS_RD:
            begin
                if (sts.p_zero)
                begin
                    cmd.wr_en   = 1'b1;
                    cmd.cnt_inc = 1'b1;
                    state_next  = S_FIN;
                end
                else
                begin
                    cmd.rd_sel = mmh_pkg::RD_PM1;
                    state_next = S_INS_CMP;
                end
            end
            S_INS_CMP:
            begin
                cmd.wr_en = 1'b1;
                if (sts.rd_gt)
                begin
                    cmd.wr_from_rd = 1'b1;
                    cmd.p_op       = mmh_pkg::P_DEC;
                    state_next     = S_INS_RD;
                end
                else
                begin
                    cmd.cnt_inc = 1'b1;
                    state_next  = S_FIN;
                end
            end
            // Capture the key at the pointer
            S_TK_RD:
            begin
                cmd.rd_sel = mmh_pkg::RD_P;
                state_next = S_TK_CAP;
            end
            S_TK_CAP:
            begin
                cmd.set_taken = 1'b1;
                state_next    = S_SH_RD;
            end
            // Close the gap by moving later keys down one slot
            S_SH_RD:
            begin
                if (sts.p1_end)
                begin
                    cmd.cnt_dec = 1'b1;
                    state_next  = S_FIN;
                end
                else
                begin
                    cmd.rd_sel = mmh_pkg::RD_PP1;
                    state_next = S_SH_WR;
                end
            end
            S_SH_WR:
            begin
                cmd.wr_en      = 1'b1;
                cmd.wr_from_rd = 1'b1;
                cmd.p_op       = mmh_pkg::P_INC;
                state_next     = S_SH_RD;
            end
            // Scan for the requested key
            S_SC_RD:
            begin
                if (sts.p_end)
                begin
                    cmd.set_status  = 1'b1;
                    cmd.status_code = mmh_pkg::ST_NOTFOUND;
                    state_next      = S_FIN;
                end
                else
                begin
                    cmd.rd_sel = mmh_pkg::RD_P;
                    state_next = S_SC_CMP;
                end
            end
            S_SC_CMP:
            begin
                if (sts.rd_eq)
                begin
                    cmd.set_found = 1'b1;
                    if (sts.op == mmh_pkg::OP_REMOVE)
                    begin
                        cmd.set_taken = 1'b1;
                        state_next    = S_SH_RD;
                    end
                    else
                    begin
                        state_next = S_FIN;
                    end
                end
                else
                begin
                    cmd.p_op   = mmh_pkg::P_INC;
                    state_next = S_SC_RD;
                end
            end
            // Fetch the smallest and largest keys, or clear both when the queue is empty
            S_FIN:
            begin
                if (sts.count_zero)
                begin
                    cmd.minmax_clr = 1'b1;
                    state_next     = S_DONE;
                end
                else
                begin
                    cmd.rd_sel = mmh_pkg::RD_ZERO;
                    state_next = S_FIN_MIN;
                end
            end
            S_FIN_MIN:
            begin
                cmd.min_ld = 1'b1;
                cmd.rd_sel = mmh_pkg::RD_LAST;
                state_next = S_FIN_MAX;
            end
            S_FIN_MAX:
            begin
                cmd.max_ld = 1'b1;
                state_next = S_DONE;
            end
            // Hand the result to the output register once it is free
            S_DONE:
            begin
                if (!sts.out_busy)
                begin
                    cmd.out_ld = 1'b1;
                    state_next = S_IDLE;
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= S_IDLE;
        end
        else
        begin
            state_reg <= state_next;
        end
    end

endmodule
`default_nettype wire

// File: hdl/min_max_heap_engine.sv
// ----------------------------------------------------------------------------
// min_max_heap_engine: double-ended priority queue
// Insert, delete-min, remove and search take longer the more keys are held,
// as the key store shifts or scans one slot per read and write; delete-max
// does not depend on the number of keys held. One transaction at a time;
// result-side stalls delay completion.
// Reset empties the queue at once; no clearing pass is needed.
// ----------------------------------------------------------------------------
`default_nettype none
`include "assert_macros.svh"
module min_max_heap_engine #(
    parameter int CAPACITY = mmh_pkg::CAPACITY_DEF
) (
    input  wire logic               clk,
    input  wire logic               rst_n,
    input  wire logic               in_valid,
    output logic                    in_stall,
    input  wire logic [2:0]         operation,
    input  wire logic signed [31:0] value,
    output logic                    out_valid,
    input  wire logic               out_stall,
    output logic [1:0]              status,
    output logic                    found,
    output logic signed [31:0]      taken_value,
    output logic signed [31:0]      min_value,
    output logic signed [31:0]      max_value,
    output logic [9:0]              entry_count
);

    mmh_pkg::cmd_t cmd;
    mmh_pkg::sts_t sts;
    logic          res_held;
    logic          res_failed;

    mmh_ctrl u_ctrl (
        .clk      (clk),
        .rst_n    (rst_n),
        .in_valid (in_valid),
        .in_stall (in_stall),
        .sts      (sts),
        .cmd      (cmd)
    );

    mmh_datapath #(
        .CAPACITY (CAPACITY)
    ) u_datapath (
        .clk         (clk),
        .rst_n       (rst_n),
        .operation   (operation),
        .value       (value),
        .cmd         (cmd),
        .sts         (sts),
        .out_stall   (out_stall),
        .out_valid   (out_valid),
        .status      (status),
        .found       (found),
        .taken_value (taken_value),
        .min_value   (min_value),
        .max_value   (max_value),
        .entry_count (entry_count)
    );

    // Classify the presented result for the checks below
    assign res_held   = (entry_count != 10'd0);
    assign res_failed = (status == mmh_pkg::ST_FULL) || (status == mmh_pkg::ST_EMPTY);

    // An accepted transaction keeps the block busy
    `ASSERT_NEXT(a_busy_after_accept, clk, rst_n, in_valid && !in_stall, in_stall)
    // Keys stay ordered: the maximum never falls below the minimum
    `ASSERT_SAME(a_min_le_max, clk, rst_n, out_valid && res_held, max_value >= min_value)
    // Failed full or empty requests take nothing out
    `ASSERT_SAME(a_fail_no_take, clk, rst_n, out_valid && res_failed, !found && (taken_value == '0))
    // A loaded result always coincides with the sequencer leaving its last step
    `ASSERT_NEXT(a_out_load, clk, rst_n, cmd.out_ld, out_valid && !in_stall)

endmodule
`default_nettype wire

// File: dv/min_max_heap_engine_test.sv
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// min_max_heap_engine_test
// Drives insert, delete, remove and search requests into the heap engine and
// checks every result against a sorted-list model of the held keys. Covers
// the empty queue, extreme keys and duplicates, random traffic under three
// idling mixes on the request and result sides, then the full queue.
// ----------------------------------------------------------------------------

typedef struct {
    logic [1:0]         status;
    logic               found;
    logic signed [31:0] taken_value;
    logic signed [31:0] min_value;
    logic signed [31:0] max_value;
    logic [9:0]         entry_count;
} heap_result_t;

class heap_scoreboard;
    int             capacity;
    int             errors;
    int             held_keys[$];     // kept in ascending order
    heap_result_t   pending_results[$];

    function new(int cap);
        capacity = cap;
        errors   = 0;
    endfunction

    function int pending();
        return pending_results.size();
    endfunction

    function int held();
        return held_keys.size();
    endfunction

    // Apply one accepted request to the key list and queue its result.
    function void note_request(logic [2:0] op, logic signed [31:0] key);
        heap_result_t r;
        int pos;
        r.status      = mmh_pkg::ST_OK;
        r.found       = 1'b0;
        r.taken_value = 0;
        pos = -1;
        if (op == mmh_pkg::OP_INSERT) begin
            if (held_keys.size() >= capacity) r.status = mmh_pkg::ST_FULL;
            else begin
                pos = 0;
                while (pos < held_keys.size() && held_keys[pos] <= key) pos++;
                held_keys.insert(pos, key);
            end
        end
        else if (op == mmh_pkg::OP_DELMIN || op == mmh_pkg::OP_DELMAX) begin
            if (held_keys.size() == 0) r.status = mmh_pkg::ST_EMPTY;
            else if (op == mmh_pkg::OP_DELMIN) r.taken_value = held_keys.pop_front();
            else r.taken_value = held_keys.pop_back();
        end
        else if (op == mmh_pkg::OP_REMOVE || op == mmh_pkg::OP_SEARCH) begin
            if (held_keys.size() == 0) r.status = mmh_pkg::ST_EMPTY;
            else begin
                for (int i = 0; i < held_keys.size(); i++)
                    if (held_keys[i] == key && pos < 0) pos = i;
                if (pos < 0) r.status = mmh_pkg::ST_NOTFOUND;
                else begin
                    r.found = 1'b1;
                    if (op == mmh_pkg::OP_REMOVE) begin
                        r.taken_value = key;
                        held_keys.delete(pos);
                    end
                end
            end
        end
        r.min_value   = held_keys.size() ? held_keys[0] : 0;
        r.max_value   = held_keys.size() ? held_keys[held_keys.size() - 1] : 0;
        r.entry_count = 10'(held_keys.size());
        pending_results.push_back(r);
    endfunction

    // Compare one accepted result with the oldest expectation.
    function void check_result(heap_result_t got);
        heap_result_t e;
        if (pending_results.size() == 0) begin
            $error("result with no request outstanding");
            errors++;
            return;
        end
        e = pending_results.pop_front();
        if (got.status !== e.status) begin
            $error("status: expected %0d, got %0d", e.status, got.status);
            errors++;
        end
        if (got.found !== e.found) begin
            $error("found: expected %0d, got %0d", e.found, got.found);
            errors++;
        end
        if (got.taken_value !== e.taken_value) begin
            $error("taken_value: expected %0d, got %0d", e.taken_value, got.taken_value);
            errors++;
        end
        if (got.min_value !== e.min_value) begin
            $error("min_value: expected %0d, got %0d", e.min_value, got.min_value);
            errors++;
        end
        if (got.max_value !== e.max_value) begin
            $error("max_value: expected %0d, got %0d", e.max_value, got.max_value);
            errors++;
        end
        if (got.entry_count !== e.entry_count) begin
            $error("entry_count: expected %0d, got %0d", e.entry_count, got.entry_count);
            errors++;
        end
    endfunction
endclass

module min_max_heap_engine_test;
    localparam int CAP        = mmh_pkg::CAPACITY_DEF;
    localparam int STALL_LIMIT = 20000;
    localparam int RAND_ITEMS = 135;

    logic               clk;
    logic               rst_n;
    logic               in_valid;
    logic               in_stall;
    logic [2:0]         operation;
    logic signed [31:0] value;
    logic               out_valid;
    logic               out_stall;
    logic [1:0]         status;
    logic               found;
    logic signed [31:0] taken_value;
    logic signed [31:0] min_value;
    logic signed [31:0] max_value;
    logic [9:0]         entry_count;

    int send_idle_pct;
    int recv_idle_pct;
    int quiet_cycles;
    heap_scoreboard sb;
    heap_result_t   seen;

    min_max_heap_engine #(.CAPACITY(CAP)) dut (
        .clk         (clk),
        .rst_n       (rst_n),
        .in_valid    (in_valid),
        .in_stall    (in_stall),
        .operation   (operation),
        .value       (value),
        .out_valid   (out_valid),
        .out_stall   (out_stall),
        .status      (status),
        .found       (found),
        .taken_value (taken_value),
        .min_value   (min_value),
        .max_value   (max_value),
        .entry_count (entry_count)
    );

    // Generate the 4 ns clock
    always
    begin
        clk = 1'b1;
        #2;
        clk = 1'b0;
        #2;
    end

    // Stall the result side at random
    always @(negedge clk)
    begin
        out_stall <= ($urandom_range(99) < recv_idle_pct);
    end

    // Check each result transaction and watch for a hung block
    always @(posedge clk)
    begin
        if (rst_n && out_valid && !out_stall) begin
            seen.status      = status;
            seen.found       = found;
            seen.taken_value = taken_value;
            seen.min_value   = min_value;
            seen.max_value   = max_value;
            seen.entry_count = entry_count;
            sb.check_result(seen);
        end
        if ((in_valid && !in_stall) || (out_valid && !out_stall) || !rst_n)
            quiet_cycles <= 0;
        else if (quiet_cycles >= STALL_LIMIT) begin
            $display("FAIL min_max_heap_engine");
            $finish;
        end
        else
            quiet_cycles <= quiet_cycles + 1;
    end

    // Offer one request, idling first at random, and hold it until taken
    task automatic send_request(logic [2:0] op, logic signed [31:0] key);
        while ($urandom_range(99) < send_idle_pct) begin
            @(negedge clk);
            in_valid = 1'b0;
        end
        @(negedge clk);
        in_valid  = 1'b1;
        operation = op;
        value     = key;
        @(posedge clk);
        while (in_stall) @(posedge clk);
        sb.note_request(op, key);
    endtask

    // Drop valid and hold until every result has come back
    task automatic drain();
        @(negedge clk);
        in_valid = 1'b0;
        while (sb.pending() != 0) @(posedge clk);
    endtask

    function automatic logic signed [31:0] pick_key();
        int r;
        r = $urandom_range(99);
        if (r < 75) return $signed($urandom_range(16)) - 8;
        if (r < 85 && sb.held() != 0) return sb.held_keys[$urandom_range(sb.held() - 1)];
        return $urandom;
    endfunction

    task automatic random_phase(int n);
        int r;
        logic [2:0] op;
        for (int i = 0; i < n; i++) begin
            r = $urandom_range(99);
            if (r < 3) op = 3'($urandom_range(7, 5));
            else if (sb.held() > 48) op = (r < 50) ? mmh_pkg::OP_DELMIN : mmh_pkg::OP_DELMAX;
            else if (r < 40) op = mmh_pkg::OP_INSERT;
            else if (r < 55) op = mmh_pkg::OP_DELMIN;
            else if (r < 70) op = mmh_pkg::OP_DELMAX;
            else if (r < 85) op = mmh_pkg::OP_REMOVE;
            else op = mmh_pkg::OP_SEARCH;
            send_request(op, pick_key());
            // hold off now and then until the engine is fully idle
            if ($urandom_range(99) == 0) drain();
        end
    endtask

    initial
    begin
        sb            = new(CAP);
        rst_n         = 1'b0;
        in_valid      = 1'b0;
        operation     = mmh_pkg::OP_INSERT;
        value         = 0;
        out_stall     = 1'b0;
        quiet_cycles  = 0;
        send_idle_pct = 25;
        recv_idle_pct = 65;
        repeat (9) @(posedge clk);
        @(negedge clk);
        rst_n = 1'b1;

        // Requests on an empty queue, and undefined operation codes
        send_request(mmh_pkg::OP_DELMIN, 0);
        send_request(mmh_pkg::OP_DELMAX, 0);
        send_request(mmh_pkg::OP_REMOVE, 5);
        send_request(mmh_pkg::OP_SEARCH, 5);
        send_request(3'd5, -1);
        send_request(3'd6, 32'h7fffffff);
        send_request(3'd7, 32'h80000000);
        // Delete-max with a single key held
        send_request(mmh_pkg::OP_INSERT, 9);
        send_request(mmh_pkg::OP_DELMAX, 0);
        // Extreme keys and duplicates
        send_request(mmh_pkg::OP_INSERT, 32'sh80000000);
        send_request(mmh_pkg::OP_INSERT, 32'sh7fffffff);
        send_request(mmh_pkg::OP_INSERT, 0);
        send_request(mmh_pkg::OP_INSERT, 0);
        send_request(mmh_pkg::OP_INSERT, -1);
        send_request(mmh_pkg::OP_SEARCH, 0);
        send_request(mmh_pkg::OP_SEARCH, 3);
        send_request(mmh_pkg::OP_REMOVE, 3);
        send_request(mmh_pkg::OP_REMOVE, 0);
        send_request(mmh_pkg::OP_SEARCH, 0);
        send_request(mmh_pkg::OP_DELMAX, 0);
        send_request(mmh_pkg::OP_DELMIN, 0);

        // Random traffic under three idling mixes
        random_phase(RAND_ITEMS);
        drain();
        send_idle_pct = 65;
        recv_idle_pct = 25;
        random_phase(RAND_ITEMS);
        send_idle_pct = 0;
        recv_idle_pct = 0;
        random_phase(RAND_ITEMS);
        drain();

        // Fill to capacity, overflow once, search, then delete from a full queue
        while (sb.held() < CAP) send_request(mmh_pkg::OP_INSERT, $urandom);
        send_request(mmh_pkg::OP_INSERT, 1);
        send_request(mmh_pkg::OP_SEARCH, 32'sh7fffffff);
        send_request(mmh_pkg::OP_DELMIN, 0);
        send_request(mmh_pkg::OP_DELMAX, 0);
        drain();

        repeat (50) @(posedge clk);
        if (sb.pending() != 0) begin
            $error("results still outstanding at end: %0d", sb.pending());
            sb.errors++;
        end
        if (sb.errors == 0)
            $display("PASS min_max_heap_engine");
        else
            $display("FAIL min_max_heap_engine");
        $finish;
    end
endmodule
